### sv/fcrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrl_pkg
// Shared types, codes and defaults of the flash counter record log.
// ----------------------------------------------------------------------------
package fcrl_pkg;

    localparam int DEF_PAGE_BYTES   = 1024;
    localparam int DEF_NUM_COUNTERS = 5;

    // results kept per item, and a count wide enough to hold that number
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int QUEUE_DEPTH = 2;

    // input kind codes
    localparam logic [1:0] KIND_RESTORE = 2'd0;
    localparam logic [1:0] KIND_NOTIFY  = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;

    // result op codes
    localparam logic [1:0] OP_PROGRAM  = 2'd0;
    localparam logic [1:0] OP_ERASE    = 2'd1;
    localparam logic [1:0] OP_RESTORED = 2'd2;
    localparam logic [1:0] OP_SCAN_END = 2'd3;

    // record header fields
    localparam logic [7:0] ID_ERASED = 8'hff;
    localparam logic [7:0] LEN_SHORT = 8'd2;
    localparam logic [7:0] LEN_LONG  = 8'd4;

    typedef enum logic [1:0] {
        CMD_RESTORE = 2'd0,
        CMD_NOTIFY  = 2'd1,
        CMD_FLUSH   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] page_word;
        logic [2:0]  counter_index;
        logic [31:0] new_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] offset;
        logic [15:0] data_word;
        logic [2:0]  restored_index;
        logic [31:0] restored_value;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SHORT  = 2'd1,
        PH_HIGH   = 2'd2,
        PH_LOW    = 2'd3
    } phase_t;

endpackage
`default_nettype wire

### sv/fcrl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrl_in_if / fcrl_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fcrl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] page_word;
    logic [2:0]  counter_index;
    logic [31:0] new_value;

    modport source (output valid, kind, page_word, counter_index, new_value, input ready);
    modport sink   (input valid, kind, page_word, counter_index, new_value, output ready);
endinterface

interface fcrl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [10:0] offset;
    logic [15:0] data_word;
    logic [2:0]  restored_index;
    logic [31:0] restored_value;
    logic        last;

    modport source (output valid, op, offset, data_word, restored_index, restored_value, last,
                    input ready);
    modport sink   (input valid, op, offset, data_word, restored_index, restored_value, last,
                    output ready);
endinterface
`default_nettype wire

### sv/fcrl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrl_front
// Accepts input items, drops unknown kinds and notifies of counters that do not exist, registers the command.
// ----------------------------------------------------------------------------
module fcrl_front #(
    parameter int NUM_COUNTERS = fcrl_pkg::DEF_NUM_COUNTERS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    fcrl_in_if.sink           item_in,
    output logic              cmd_valid,
    output fcrl_pkg::cmd_t    cmd,
    input  wire logic         cmd_ready
);

    logic           valid_reg;
    logic           valid_next;
    fcrl_pkg::cmd_t cmd_reg;
    fcrl_pkg::cmd_t cmd_next;
    logic           keep;
    logic           take;

    assign item_in.ready = !valid_reg || cmd_ready;
    assign take          = item_in.valid && item_in.ready;
    assign cmd_valid     = valid_reg;
    assign cmd           = cmd_reg;

    always_comb
    begin
        cmd_next.kind          = fcrl_pkg::CMD_RESTORE;
        cmd_next.page_word     = item_in.page_word;
        cmd_next.counter_index = item_in.counter_index;
        cmd_next.new_value     = item_in.new_value;
        keep                   = 1'b0;
        case (item_in.kind)
            fcrl_pkg::KIND_RESTORE:
            begin
                cmd_next.kind = fcrl_pkg::CMD_RESTORE;
                keep          = 1'b1;
            end
            fcrl_pkg::KIND_NOTIFY:
            begin
                cmd_next.kind = fcrl_pkg::CMD_NOTIFY;
                // notify of a counter that does not exist is dropped here
                keep          = (32'(item_in.counter_index) < NUM_COUNTERS);
            end
            fcrl_pkg::KIND_FLUSH:
            begin
                cmd_next.kind = fcrl_pkg::CMD_FLUSH;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg && !cmd_ready;
        if (take)
        begin
            valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

### sv/fcrl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrl_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fcrl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire fcrl_pkg::cmd_t  push_cmd,
    output logic                 push_ready,
    output logic                 pop_valid,
    output fcrl_pkg::cmd_t       pop_cmd,
    input  wire logic            pop_ready
);

    localparam int DEPTH = fcrl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fcrl_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### sv/fcrl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrl_back
// Sequencer that parses restore words, stores notifies and runs flushes,
// with a one-result hold so the last flag lands on the final result.
// ----------------------------------------------------------------------------
module fcrl_back #(
    parameter int PAGE_BYTES   = fcrl_pkg::DEF_PAGE_BYTES,
    parameter int NUM_COUNTERS = fcrl_pkg::DEF_NUM_COUNTERS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire fcrl_pkg::cmd_t  cmd,
    output logic                 cmd_ready,
    fcrl_out_if.source           res_out
);

    localparam int OFS_W = $clog2(PAGE_BYTES + 6 * NUM_COUNTERS + 1);
    localparam int SP_W  = $clog2(6 * NUM_COUNTERS + 1);
    localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COUNTERS - 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_RESTORE = 9'b000000010,
        S_FINISH  = 9'b000000100,
        S_SUM     = 9'b000001000,
        S_CHECK   = 9'b000010000,
        S_HDR     = 9'b000100000,
        S_HI      = 9'b001000000,
        S_LO      = 9'b010000000,
        S_END     = 9'b100000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    fcrl_pkg::cmd_t                 cmd_reg;
    logic [31:0]                    values_reg [NUM_COUNTERS];
    logic [31:0]                    values_next [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0]        flags_reg;
    logic [NUM_COUNTERS-1:0]        flags_next;
    logic [OFS_W-1:0]               wo_reg;
    logic [OFS_W-1:0]               wo_next;
    fcrl_pkg::phase_t               phase_reg;
    fcrl_pkg::phase_t               phase_next;
    logic                           scanning_reg;
    logic                           scanning_next;
    logic [IDX_W-1:0]               pending_reg;
    logic [IDX_W-1:0]               pending_next;
    logic [15:0]                    high_reg;
    logic [15:0]                    high_next;
    logic [IDX_W-1:0]               walk_reg;
    logic [IDX_W-1:0]               walk_next;
    logic [SP_W-1:0]                space_reg;
    logic [SP_W-1:0]                space_next;

    fcrl_pkg::result_t              out_reg;
    fcrl_pkg::result_t              out_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    fcrl_pkg::result_t              hold_reg;
    fcrl_pkg::result_t              hold_next;
    logic                           hold_valid_reg;
    logic                           hold_valid_next;
    logic [fcrl_pkg::RES_CNT_W-1:0] res_cnt_reg;
    logic [fcrl_pkg::RES_CNT_W-1:0] res_cnt_next;

    logic                           step_ok;
    logic                           emit_req;
    fcrl_pkg::result_t              emit_res;
    logic                           end_req;
    logic [7:0]                     hdr_id;
    logic [7:0]                     hdr_len;
    logic [OFS_W-1:0]               wo_short;
    logic [OFS_W-1:0]               wo_long;
    logic [31:0]                    walk_value;
    logic                           walk_big;
    logic                           page_full;

    assign step_ok    = !out_valid_reg || res_out.ready;
    assign cmd_ready  = (state_reg == S_IDLE);
    assign hdr_id     = cmd_reg.page_word[15:8];
    assign hdr_len    = cmd_reg.page_word[7:0];
    assign wo_short   = wo_reg + OFS_W'(2);
    assign wo_long    = wo_reg + OFS_W'(4);
    assign walk_value = values_reg[walk_reg];
    assign walk_big   = (walk_value[31:16] != 16'h0000);
    assign page_full  = ({1'b0, wo_reg} + (OFS_W + 1)'(space_reg)) > (OFS_W + 1)'(PAGE_BYTES);

    always_comb
    begin
        state_next    = state_reg;
        values_next   = values_reg;
        flags_next    = flags_reg;
        wo_next       = wo_reg;
        phase_next    = phase_reg;
        scanning_next = scanning_reg;
        pending_next  = pending_reg;
        high_next     = high_reg;
        walk_next     = walk_reg;
        space_next    = space_reg;
        emit_req      = 1'b0;
        emit_res      = '0;
        end_req       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        fcrl_pkg::CMD_RESTORE:
                        begin
                            state_next = S_RESTORE;
                        end
                        fcrl_pkg::CMD_NOTIFY:
                        begin
                            values_next[IDX_W'(cmd.counter_index)] = cmd.new_value;
                            flags_next[IDX_W'(cmd.counter_index)]  = 1'b1;
                        end
                        fcrl_pkg::CMD_FLUSH:
                        begin
                            walk_next  = '0;
                            space_next = '0;
                            state_next = S_SUM;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESTORE:
            begin
                if (step_ok)
                begin
                    if (!scanning_reg)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        case (phase_reg)
                            fcrl_pkg::PH_HEADER:
                            begin
                                if (wo_reg >= OFS_W'(PAGE_BYTES))
                                begin
                                    state_next = S_FINISH;
                                end
                                else if (hdr_id == fcrl_pkg::ID_ERASED ||
                                         32'(hdr_id) >= NUM_COUNTERS)
                                begin
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    wo_next      = wo_short;
                                    pending_next = IDX_W'(hdr_id);
                                    if (hdr_len == fcrl_pkg::LEN_SHORT)
                                    begin
                                        phase_next = fcrl_pkg::PH_SHORT;
                                        state_next = S_END;
                                    end
                                    else if (hdr_len == fcrl_pkg::LEN_LONG)
                                    begin
                                        phase_next = fcrl_pkg::PH_HIGH;
                                        state_next = S_END;
                                    end
                                    else
                                    begin
                                        state_next = S_FINISH;
                                    end
                                end
                            end
                            fcrl_pkg::PH_SHORT:
                            begin
                                wo_next                    = wo_short;
                                values_next[pending_reg]   = {16'h0000, cmd_reg.page_word};
                                emit_req                   = 1'b1;
                                emit_res.op                = fcrl_pkg::OP_RESTORED;
                                emit_res.restored_index    = 3'(pending_reg);
                                emit_res.restored_value    = {16'h0000, cmd_reg.page_word};
                                phase_next                 = fcrl_pkg::PH_HEADER;
                                state_next = (wo_short >= OFS_W'(PAGE_BYTES)) ? S_FINISH : S_END;
                            end
                            fcrl_pkg::PH_HIGH:
                            begin
                                high_next  = cmd_reg.page_word;
                                phase_next = fcrl_pkg::PH_LOW;
                                state_next = S_END;
                            end
                            default:
                            begin
                                wo_next                    = wo_long;
                                values_next[pending_reg]   = {high_reg, cmd_reg.page_word};
                                emit_req                   = 1'b1;
                                emit_res.op                = fcrl_pkg::OP_RESTORED;
                                emit_res.restored_index    = 3'(pending_reg);
                                emit_res.restored_value    = {high_reg, cmd_reg.page_word};
                                phase_next                 = fcrl_pkg::PH_HEADER;
                                state_next = (wo_long >= OFS_W'(PAGE_BYTES)) ? S_FINISH : S_END;
                            end
                        endcase
                    end
                end
            end

            S_FINISH:
            begin
                if (step_ok)
                begin
                    scanning_next   = 1'b0;
                    phase_next      = fcrl_pkg::PH_HEADER;
                    emit_req        = 1'b1;
                    emit_res.op     = fcrl_pkg::OP_SCAN_END;
                    emit_res.offset = 11'(wo_reg);
                    state_next      = S_END;
                end
            end

            S_SUM:
            begin
                if (flags_reg[walk_reg])
                begin
                    space_next = space_reg + (walk_big ? SP_W'(6) : SP_W'(4));
                end
                if (walk_reg == LAST_IDX)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            S_CHECK:
            begin
                if (step_ok)
                begin
                    walk_next  = '0;
                    state_next = S_HDR;
                    if (page_full)
                    begin
                        wo_next     = '0;
                        flags_next  = '1;
                        emit_req    = 1'b1;
                        emit_res.op = fcrl_pkg::OP_ERASE;
                    end
                end
            end

            S_HDR:
            begin
                if (step_ok)
                begin
                    if (flags_reg[walk_reg])
                    begin
                        flags_next[walk_reg] = 1'b0;
                        emit_req             = 1'b1;
                        emit_res.op          = fcrl_pkg::OP_PROGRAM;
                        emit_res.offset      = 11'(wo_reg);
                        emit_res.data_word   = {8'(walk_reg),
                                                walk_big ? fcrl_pkg::LEN_LONG
                                                         : fcrl_pkg::LEN_SHORT};
                        wo_next              = wo_short;
                        state_next           = walk_big ? S_HI : S_LO;
                    end
                    else if (walk_reg == LAST_IDX)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        walk_next = walk_reg + 1'b1;
                    end
                end
            end

            S_HI:
            begin
                if (step_ok)
                begin
                    emit_req           = 1'b1;
                    emit_res.op        = fcrl_pkg::OP_PROGRAM;
                    emit_res.offset    = 11'(wo_reg);
                    emit_res.data_word = walk_value[31:16];
                    wo_next            = wo_short;
                    state_next         = S_LO;
                end
            end

            S_LO:
            begin
                if (step_ok)
                begin
                    emit_req           = 1'b1;
                    emit_res.op        = fcrl_pkg::OP_PROGRAM;
                    emit_res.offset    = 11'(wo_reg);
                    emit_res.data_word = walk_value[15:0];
                    wo_next            = wo_short;
                    if (walk_reg == LAST_IDX)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        walk_next  = walk_reg + 1'b1;
                        state_next = S_HDR;
                    end
                end
            end

            S_END:
            begin
                if (step_ok)
                begin
                    end_req    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result hold: a result moves on to the output when the next one arrives
    // or when the item ends, which is when it gets its last flag
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_out.ready;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        res_cnt_next    = res_cnt_reg;
        if (emit_req && res_cnt_reg < fcrl_pkg::RES_CNT_W'(fcrl_pkg::MAX_RESULTS))
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_res;
            hold_valid_next = 1'b1;
            res_cnt_next    = res_cnt_reg + 1'b1;
        end
        if (end_req)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_next.last  = 1'b1;
                out_valid_next = 1'b1;
            end
            hold_valid_next = 1'b0;
            res_cnt_next    = '0;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.op             = out_reg.op;
    assign res_out.offset         = out_reg.offset;
    assign res_out.data_word      = out_reg.data_word;
    assign res_out.restored_index = out_reg.restored_index;
    assign res_out.restored_value = out_reg.restored_value;
    assign res_out.last           = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                values_reg[i] <= '0;
            end
            flags_reg      <= '0;
            wo_reg         <= '0;
            phase_reg      <= fcrl_pkg::PH_HEADER;
            scanning_reg   <= 1'b1;
            pending_reg    <= '0;
            high_reg       <= '0;
            walk_reg       <= '0;
            space_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            values_reg     <= values_next;
            flags_reg      <= flags_next;
            wo_reg         <= wo_next;
            phase_reg      <= phase_next;
            scanning_reg   <= scanning_next;
            pending_reg    <= pending_next;
            high_reg       <= high_next;
            walk_reg       <= walk_next;
            space_reg      <= space_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            res_cnt_reg    <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
    end

endmodule
`default_nettype wire

### sv/flash_counter_record_log_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_counter_record_log_top
// Counter record log in one flash page: startup scan, notify, flush.
//
//   channel   dir  handshake     payload
//   item_in   in   valid/ready   kind, page_word, counter_index, new_value
//   res_out   out  valid/ready   op, offset, data_word, restored_index,
//                                restored_value, last
//
// an item passes the front register and the queue, then the back sequencer
// takes it: a notify finishes in the cycle it is taken, a restore word passes
// the restore and end states, with the finish state between them when it ends
// the scan; a flush sums the space, erases a full page, then programs each
// dirty counter; the sequencer makes at most one result per cycle and stalls while the
// output register is full; the front keeps taking items until the queue fills
// reset loads all control state and counter values at once, no clearing pass
// ----------------------------------------------------------------------------
module flash_counter_record_log_top #(
    parameter int PAGE_BYTES   = fcrl_pkg::DEF_PAGE_BYTES,
    parameter int NUM_COUNTERS = fcrl_pkg::DEF_NUM_COUNTERS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fcrl_in_if.sink    item_in,
    fcrl_out_if.source res_out
);

    logic           front_valid;
    fcrl_pkg::cmd_t front_cmd;
    logic           front_ready;
    logic           back_valid;
    fcrl_pkg::cmd_t back_cmd;
    logic           back_ready;

    fcrl_front #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    fcrl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    fcrl_back #(
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .res_out   (res_out)
    );

endmodule
`default_nettype wire

### test/record_log_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_log_monitor
// Watches both channels of the record log, rebuilds the page log from the
// accepted items and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module record_log_monitor #(
    parameter int PAGE_BYTES   = fcrl_pkg::DEF_PAGE_BYTES,
    parameter int NUM_COUNTERS = fcrl_pkg::DEF_NUM_COUNTERS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fcrl_in_if        item_in,
    fcrl_out_if       res_out,
    output int        mismatches,
    output int        ops_due,
    output int        log_offset,
    output logic      scan_open
);
    import fcrl_pkg::*;

    logic [31:0] tally_val   [NUM_COUNTERS];
    logic        tally_dirty [NUM_COUNTERS];
    int          wr_offset;
    logic        scanning;
    phase_t      rec_phase;
    logic [2:0]  rec_id;
    logic [15:0] rec_high;
    int          item_results;
    result_t     flash_ops [$];

    task automatic clear_log();
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            tally_val[i]   = '0;
            tally_dirty[i] = 1'b0;
        end
        wr_offset  = 0;
        scanning   = 1'b1;
        rec_phase  = PH_HEADER;
        rec_id     = '0;
        rec_high   = '0;
        mismatches = 0;
        flash_ops.delete();
    endtask

    // anything past the per-item limit is dropped, state still moves
    task automatic queue_op(input logic [1:0] op, input int off, input logic [15:0] data,
                            input logic [2:0] idx, input logic [31:0] val);
        result_t r;
        if (item_results < MAX_RESULTS)
        begin
            r.op             = op;
            r.offset         = 11'(off);
            r.data_word      = data;
            r.restored_index = idx;
            r.restored_value = val;
            r.last           = 1'b0;
            flash_ops.push_back(r);
            item_results++;
        end
    endtask

    task automatic end_scan();
        scanning  = 1'b0;
        rec_phase = PH_HEADER;
        queue_op(OP_SCAN_END, wr_offset, '0, '0, '0);
    endtask

    task automatic land_record(input logic [31:0] val);
        tally_val[rec_id] = val;
        queue_op(OP_RESTORED, 0, '0, rec_id, val);
        rec_phase = PH_HEADER;
        if (wr_offset >= PAGE_BYTES)
            end_scan();
    endtask

    task automatic log_restore_word(input logic [15:0] w);
        if (scanning)
        begin
            case (rec_phase)
                PH_HEADER:
                begin
                    if (wr_offset >= PAGE_BYTES || w[15:8] == ID_ERASED ||
                        w[15:8] >= NUM_COUNTERS)
                        end_scan();
                    else
                    begin
                        // header is counted even when its length is bad
                        wr_offset += 2;
                        rec_id = w[10:8];
                        if (w[7:0] == LEN_SHORT)
                            rec_phase = PH_SHORT;
                        else if (w[7:0] == LEN_LONG)
                            rec_phase = PH_HIGH;
                        else
                            end_scan();
                    end
                end
                PH_SHORT:
                begin
                    wr_offset += 2;
                    land_record({16'h0000, w});
                end
                PH_HIGH:
                begin
                    rec_high  = w;
                    rec_phase = PH_LOW;
                end
                default:
                begin
                    wr_offset += 4;
                    land_record({rec_high, w});
                end
            endcase
        end
    endtask

    task automatic log_flush();
        int          need;
        logic [31:0] v;
        need = 0;
        for (int i = 0; i < NUM_COUNTERS; i++)
            if (tally_dirty[i])
                need += (tally_val[i] > 32'h0000_ffff) ? 6 : 4;
        if (wr_offset + need > PAGE_BYTES)
        begin
            wr_offset = 0;
            queue_op(OP_ERASE, 0, '0, '0, '0);
            for (int i = 0; i < NUM_COUNTERS; i++)
                tally_dirty[i] = 1'b1;
        end
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            if (tally_dirty[i])
            begin
                tally_dirty[i] = 1'b0;
                v = tally_val[i];
                if (v > 32'h0000_ffff)
                begin
                    queue_op(OP_PROGRAM, wr_offset, {8'(i), LEN_LONG}, '0, '0);
                    queue_op(OP_PROGRAM, wr_offset + 2, v[31:16], '0, '0);
                    queue_op(OP_PROGRAM, wr_offset + 4, v[15:0], '0, '0);
                    wr_offset += 6;
                end
                else
                begin
                    queue_op(OP_PROGRAM, wr_offset, {8'(i), LEN_SHORT}, '0, '0);
                    queue_op(OP_PROGRAM, wr_offset + 2, v[15:0], '0, '0);
                    wr_offset += 4;
                end
            end
        end
    endtask

    task automatic log_item(input logic [1:0] k, input logic [15:0] w, input logic [2:0] idx,
                            input logic [31:0] v);
        result_t tail;
        item_results = 0;
        case (k)
            KIND_RESTORE:
                log_restore_word(w);
            KIND_NOTIFY:
            begin
                if (idx < NUM_COUNTERS)
                begin
                    tally_val[idx]   = v;
                    tally_dirty[idx] = 1'b1;
                end
            end
            KIND_FLUSH:
                log_flush();
            default:
                ;
        endcase
        if (item_results > 0)
        begin
            tail      = flash_ops.pop_back();
            tail.last = 1'b1;
            flash_ops.push_back(tail);
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        result_t want;
        if (!rst_n)
            clear_log();
        else
        begin
            if (item_in.valid && item_in.ready)
                log_item(item_in.kind, item_in.page_word, item_in.counter_index,
                         item_in.new_value);
            if (res_out.valid && res_out.ready)
            begin
                if (flash_ops.size() == 0)
                begin
                    $error("result with none pending: op %0d offset %0d data 0x%0h",
                           res_out.op, res_out.offset, res_out.data_word);
                    mismatches++;
                end
                else
                begin
                    want = flash_ops.pop_front();
                    compare_field("op", want.op, res_out.op);
                    compare_field("offset", want.offset, res_out.offset);
                    compare_field("data_word", want.data_word, res_out.data_word);
                    compare_field("restored_index", want.restored_index,
                                  res_out.restored_index);
                    compare_field("restored_value", want.restored_value,
                                  res_out.restored_value);
                    compare_field("last", want.last, res_out.last);
                end
            end
        end
        ops_due    = flash_ops.size();
        log_offset = wr_offset;
        scan_open  = scanning;
    end

endmodule

### test/flash_counter_record_log_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_counter_record_log_top_tb
// Feeds a startup page scan of well-formed records ending in one of the ways a
// scan can end, then notify and flush traffic up to a page erase, with bursty
// input and a stalling result side; record_log_monitor does the checking.
// ----------------------------------------------------------------------------
module flash_counter_record_log_top_tb;
    import fcrl_pkg::*;

    localparam int         PAGE_BYTES   = DEF_PAGE_BYTES;
    localparam int         NUM_COUNTERS = DEF_NUM_COUNTERS;
    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RANDOM_ITEMS = 130;
    localparam int         FLUSH_BYTES  = 6 * NUM_COUNTERS;

    typedef enum int {
        END_ERASED_ID,
        END_BAD_ID,
        END_BAD_LEN,
        END_PAGE_FULL,
        END_FLUSH_FULL
    } scan_end_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcrl_in_if  item_in ();
    fcrl_out_if res_out ();

    int   mismatches;
    int   ops_due;
    int   log_offset;
    logic scan_open;

    bit hold_req   = 1'b0;
    int burst_left = 0;
    int rx_tick    = 0;
    int rx_mode    = 0;
    int hold_count;

    flash_counter_record_log_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .res_out (res_out)
    );

    record_log_monitor #(
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .res_out    (res_out),
        .mismatches (mismatches),
        .ops_due    (ops_due),
        .log_offset (log_offset),
        .scan_open  (scan_open)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_ffff;
            2:       return 32'h0001_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(0, 65535));
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] k, input logic [15:0] w, input logic [2:0] idx,
                             input logic [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            item_in.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_in.valid         = 1'b1;
        item_in.kind          = k;
        item_in.page_word     = w;
        item_in.counter_index = idx;
        item_in.new_value     = v;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_word(input logic [15:0] w);
        send_item(KIND_RESTORE, w, 3'($urandom), $urandom());
    endtask

    task automatic notify(input int idx, input logic [31:0] v);
        send_item(KIND_NOTIFY, 16'($urandom), 3'(idx), v);
    endtask

    task automatic flush_tick();
        send_item(KIND_FLUSH, 16'($urandom), 3'($urandom), $urandom());
    endtask

    task automatic send_record(input int id, input logic [31:0] v, input logic is_long);
        send_word({8'(id), is_long ? LEN_LONG : LEN_SHORT});
        if (is_long)
        begin
            send_word(v[31:16]);
            send_word(v[15:0]);
        end
        else
            send_word(v[15:0]);
    endtask

    task automatic drain_results();
        item_in.valid = 1'b0;
        burst_left    = 0;
        while (ops_due != 0)
            @(negedge clk);
    endtask

    // result side: switches among random ready patterns, long hold-off on request
    initial
    begin
        res_out.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_req)
            begin
                res_out.ready = 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            if (rx_tick % 50 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       res_out.ready = 1'b1;
                1:       res_out.ready = ($urandom_range(0, 9) < 8);
                2:       res_out.ready = ($urandom_range(0, 3) == 0);
                default: res_out.ready = (rx_tick % 5 < 2);
            endcase
        end
    end

    initial
    begin
        scan_end_t   ending;
        logic [7:0]  bad_len;
        int          room;
        int          n_long;
        int          n_short;
        int          counted;
        int          pick;
        int          prev;
        bit          filled;

        item_in.valid         = 1'b0;
        item_in.kind          = KIND_RESTORE;
        item_in.page_word     = '0;
        item_in.counter_index = '0;
        item_in.new_value     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // startup scan: extremes of short and long records
        send_record(0, 32'h0000_0000, 1'b0);
        send_record(NUM_COUNTERS - 1, 32'hffff_ffff, 1'b1);
        send_record(1, 32'h0000_ffff, 1'b0);
        // notify and flush land between a long header and its data
        send_word({8'd2, LEN_LONG});
        notify(2, 32'h0001_0000);
        flush_tick();
        send_word(16'h0001);
        send_word(16'h0000);
        notify(NUM_COUNTERS, $urandom());
        notify(7, $urandom());
        send_item(KIND_NONE, 16'($urandom), 3'($urandom), $urandom());
        send_record(3, 32'h0000_1234, 1'b1);

        repeat ($urandom_range(4, 12))
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    notify($urandom_range(0, NUM_COUNTERS - 1), pick_value());
                else
                    flush_tick();
            end
            send_record($urandom_range(0, NUM_COUNTERS - 1), pick_value(),
                        1'($urandom_range(0, 1)));
        end

        ending = scan_end_t'($urandom_range(0, 4));
        case (ending)
            END_ERASED_ID:
                send_word({ID_ERASED, 8'($urandom)});
            END_BAD_ID:
                send_word({8'($urandom_range(NUM_COUNTERS, 254)), 8'($urandom)});
            END_BAD_LEN:
            begin
                do
                    bad_len = 8'($urandom);
                while (bad_len == LEN_SHORT || bad_len == LEN_LONG);
                send_word({8'($urandom_range(0, NUM_COUNTERS - 1)), bad_len});
            end
            END_PAGE_FULL:
                while (scan_open)
                    send_record($urandom_range(0, NUM_COUNTERS - 1), pick_value(),
                                1'($urandom_range(0, 1)));
            default:
            begin
                // a flush fills the page exactly, the next word ends the scan
                flush_tick();
                while (scan_open && PAGE_BYTES - log_offset > FLUSH_BYTES)
                    send_record($urandom_range(0, NUM_COUNTERS - 1), pick_value(), 1'b0);
                if (scan_open)
                begin
                    room   = PAGE_BYTES - log_offset;
                    n_long = -1;
                    for (int a = 0; a <= NUM_COUNTERS; a++)
                        if (n_long < 0 && room >= 6 * a && (room - 6 * a) % 4 == 0 &&
                            a + (room - 6 * a) / 4 <= NUM_COUNTERS)
                            n_long = a;
                    if (n_long >= 0)
                    begin
                        n_short = (room - 6 * n_long) / 4;
                        for (int i = 0; i < n_long; i++)
                            notify(i, 32'h0001_0000 | $urandom());
                        for (int i = n_long; i < n_long + n_short; i++)
                            notify(i, 32'($urandom_range(0, 65535)));
                        flush_tick();
                        send_word(16'($urandom));
                    end
                end
                while (scan_open)
                    send_record($urandom_range(0, NUM_COUNTERS - 1), pick_value(), 1'b0);
            end
        endcase
        // scan is over, these words are dropped
        send_word(16'($urandom));
        send_word({8'd0, LEN_SHORT});
        drain_results();

        notify(0, 32'h0000_0000);
        notify(NUM_COUNTERS - 1, 32'hffff_ffff);
        notify(1, 32'h0001_0000);
        notify(3, 32'h0000_ffff);
        flush_tick();
        flush_tick();
        notify(2, 32'h0000_0001);
        notify(2, 32'h8000_0000);
        flush_tick();
        drain_results();

        // result side holds off while full flushes pile up behind it
        hold_req = 1'b1;
        repeat (3)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                notify(i, pick_value());
            flush_tick();
        end

        counted = 0;
        filled  = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (!filled && counted >= RANDOM_ITEMS / 2)
            begin
                // grow the log until a flush has to erase the page
                filled = 1'b1;
                for (int round = 0; round < 60; round++)
                begin
                    prev = log_offset;
                    for (int i = 0; i < NUM_COUNTERS; i++)
                        notify(i, pick_value());
                    flush_tick();
                    if (log_offset <= prev)
                        break;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                notify($urandom_range(0, NUM_COUNTERS - 1), pick_value());
                counted++;
            end
            else if (pick < 58)
                notify($urandom_range(NUM_COUNTERS, 7), $urandom());
            else if (pick < 82)
            begin
                flush_tick();
                counted++;
            end
            else if (pick < 92)
                send_word(16'($urandom));
            else
                send_item(KIND_NONE, 16'($urandom), 3'($urandom), $urandom());
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
